// ----- rtl/fircd_pkg.sv -----
// fircd_pkg: shared types and constants of the circular delay fir filter
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps

package fircd_pkg;

    localparam int CMD_W      = 2;
    localparam int TAP_IDX_W  = 6;
    localparam int TAPS_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILTER    = 2'd0,
        CMD_TAP_WRITE = 2'd1,
        CMD_CLEAR     = 2'd2
    } cmd_code_t;

    localparam logic [CFG_IDX_W-1:0] REG_BYPASS      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic cap_sample;
        logic tap_wr;
        logic clear;
        logic wr_delay;
        logic issue;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bypass;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- rtl/fircd_ctrl.sv -----
// fircd_ctrl: sequencing state machine of the fir filter
// depends on fircd_pkg; drives the datapath through dp_cmd_t
`timescale 1ns / 1ps

module fircd_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [fircd_pkg::CMD_W-1:0] s_command,
    input  fircd_pkg::dp_sts_t        sts,
    output fircd_pkg::dp_cmd_t        cmd
);
    import fircd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WRITE = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        CMD_FILTER: begin
                            cmd.cap_sample = 1'b1;
                            state_next     = sts.bypass ? ST_OUT : ST_WRITE;
                        end
                        CMD_TAP_WRITE: cmd.tap_wr = 1'b1;
                        CMD_CLEAR:     cmd.clear  = 1'b1;
                        default:       ;
                    endcase
                end
            end
            ST_WRITE: begin
                cmd.wr_delay = 1'b1;
                state_next   = ST_RUN;
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (sts.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !s_ready && !cmd.load_out)
        else $error("issue overlaps accept or output load");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("output loaded while occupied");

    a_drain_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && sts.last_issue |=> state_reg == ST_DRAIN)
        else $error("run did not end in drain");

endmodule

// ----- rtl/fircd_dp.sv -----
// fircd_dp: delay and tap memories, shared multiply-accumulate, rounding,
// saturation and the output register; depends on fircd_pkg
`timescale 1ns / 1ps

module fircd_dp #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fircd_pkg::dp_cmd_t               cmd,
    output fircd_pkg::dp_sts_t               sts,
    input  logic                             cfg_wr_en,
    input  logic [fircd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fircd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic signed [SAMPLE_WIDTH-1:0]   s_sample_in,
    input  logic                             s_block_last_in,
    input  logic [fircd_pkg::TAP_IDX_W-1:0]  s_tap_index,
    input  logic signed [COEF_WIDTH-1:0]     s_tap_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   m_sample_out,
    output logic                             m_saturated,
    output logic                             m_block_last_out
);
    import fircd_pkg::*;

    localparam int AW      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int FULL_W  = PROD_W + AW;
    localparam int ACC_W   = (FULL_W > 64) ? 64 : FULL_W;
    localparam int SHW     = ACC_W - COEF_WIDTH + 1;
    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (COEF_WIDTH - 2);
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // configuration
    logic                 bypass_reg;
    logic [TAPS_W-1:0]    taps_reg;

    // item state
    logic [AW-1:0]        wp_reg;
    logic [AW-1:0]        nm1_reg;
    logic [AW-1:0]        pos_reg;
    logic [AW-1:0]        j_reg;
    logic [AW-1:0]        rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                 last_reg;
    logic                 byp_reg;

    // memories and valid bits
    logic signed [SAMPLE_WIDTH-1:0] dly_mem [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0]   tap_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]  dly_vld_reg;
    logic [MAX_TAPS-1:0]  tap_vld_reg;

    // mac pipeline
    logic signed [SAMPLE_WIDTH-1:0] dly_q_reg;
    logic signed [COEF_WIDTH-1:0]   tap_q_reg;
    logic                 dly_qv_reg;
    logic                 tap_qv_reg;
    logic                 rd_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                 mul_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // output register
    logic                 m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                 out_sat_reg;
    logic                 out_last_reg;

    logic [AW-1:0]        nm1_cfg;
    logic [AW-1:0]        pos_cfg;
    logic [AW-1:0]        tap_addr;
    logic                 tap_idx_ok;
    logic signed [SAMPLE_WIDTH-1:0] dly_op;
    logic signed [COEF_WIDTH-1:0]   tap_op;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shr_full;
    logic signed [SHW-1:0]    shr;
    logic [SHW-SAMPLE_WIDTH:0] shr_top;
    logic                 clip;
    logic signed [SAMPLE_WIDTH-1:0] filt_out;

    always_comb begin
        if (taps_reg == '0) begin
            nm1_cfg = '0;
        end else if (32'(taps_reg) > 32'(MAX_TAPS)) begin
            nm1_cfg = AW'(MAX_TAPS - 1);
        end else begin
            nm1_cfg = AW'(taps_reg - TAPS_W'(1));
        end
    end

    assign pos_cfg    = (wp_reg <= nm1_cfg) ? wp_reg : '0;
    assign tap_addr   = AW'(s_tap_index);
    assign tap_idx_ok = 32'(s_tap_index) < 32'(MAX_TAPS);

    assign sts.bypass     = bypass_reg;
    assign sts.last_issue = (j_reg == nm1_reg);
    assign sts.pipe_busy  = rd_vld_reg || mul_vld_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg <= 1'b0;
            taps_reg   <= TAPS_W'(MAX_TAPS);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BYPASS:      bypass_reg <= cfg_wr_data[0];
                REG_TAPS_IN_USE: taps_reg   <= cfg_wr_data[TAPS_W-1:0];
                default:         ;
            endcase
        end
    end

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            dly_vld_reg <= '0;
            tap_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg  <= cmd.issue;
            mul_vld_reg <= rd_vld_reg;
            if (cmd.clear) begin
                dly_vld_reg <= '0;
                wp_reg      <= '0;
            end
            if (cmd.tap_wr && tap_idx_ok) begin
                tap_vld_reg[tap_addr] <= 1'b1;
            end
            if (cmd.wr_delay) begin
                dly_vld_reg[pos_reg] <= 1'b1;
                wp_reg <= (pos_reg == nm1_reg) ? '0 : pos_reg + AW'(1);
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.tap_wr && tap_idx_ok) begin
            tap_mem[tap_addr] <= s_tap_value;
        end
        if (cmd.wr_delay) begin
            dly_mem[pos_reg] <= sample_reg;
        end
        if (cmd.issue) begin
            tap_q_reg  <= tap_mem[j_reg];
            dly_q_reg  <= dly_mem[rd_reg];
            tap_qv_reg <= tap_vld_reg[j_reg];
            dly_qv_reg <= dly_vld_reg[rd_reg];
        end
    end

    assign tap_op = tap_qv_reg ? tap_q_reg : '0;
    assign dly_op = dly_qv_reg ? dly_q_reg : '0;

    // payload and mac
    always_ff @(posedge aclk) begin
        if (cmd.cap_sample) begin
            sample_reg <= s_sample_in;
            last_reg   <= s_block_last_in;
            byp_reg    <= bypass_reg;
            nm1_reg    <= nm1_cfg;
            pos_reg    <= pos_cfg;
        end
        if (cmd.wr_delay) begin
            j_reg   <= '0;
            rd_reg  <= pos_reg;
            acc_reg <= '0;
        end else begin
            if (cmd.issue) begin
                j_reg  <= j_reg + AW'(1);
                rd_reg <= (rd_reg == '0) ? nm1_reg : rd_reg - AW'(1);
            end
            if (mul_vld_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
        prod_reg <= tap_op * dly_op;
        if (cmd.load_out) begin
            out_last_reg <= last_reg;
            if (byp_reg) begin
                out_sample_reg <= sample_reg;
                out_sat_reg    <= 1'b0;
            end else begin
                out_sample_reg <= filt_out;
                out_sat_reg    <= clip;
            end
        end
    end

    // round half up, then clip
    assign rnd      = acc_reg + RND_BIAS;
    assign shr_full = rnd >>> (COEF_WIDTH - 1);
    assign shr      = shr_full[SHW-1:0];
    assign shr_top  = shr[SHW-1:SAMPLE_WIDTH-1];
    assign clip     = !((&shr_top) || !(|shr_top));
    assign filt_out = clip ? (shr[SHW-1] ? S_MIN : S_MAX) : shr[SAMPLE_WIDTH-1:0];

    assign m_valid          = m_valid_reg;
    assign m_sample_out     = out_sample_reg;
    assign m_saturated      = out_sat_reg;
    assign m_block_last_out = out_last_reg;

    a_issue_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> j_reg <= nm1_reg)
        else $error("tap counter past active length");

    a_wp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_delay |=> wp_reg <= nm1_reg)
        else $error("write position left active range");

    a_drained_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out && !byp_reg |-> !rd_vld_reg && !mul_vld_reg)
        else $error("result loaded before mac pipeline drained");

endmodule

// ----- rtl/fir_filter_circular_delay_top.sv -----
// fir_filter_circular_delay_top: direct-form fir filter over a circular delay line
// depends on fircd_pkg, fircd_ctrl and fircd_dp
//
//   channel   ports                                                   handshake
//   input     s_command s_sample_in s_block_last_in s_tap_index       s_valid/s_ready
//             s_tap_value
//   result    m_sample_out m_saturated m_block_last_out               m_valid/m_ready
//   config    cfg_index cfg_wr_data                                   cfg_wr_en
//
// filtered sample: capture, delay write, then one shared multiplier walks the taps
// at one per cycle; read, product and accumulator registers drain before output load
// bypassed samples go straight to output load; tap writes and clears stay in idle
// memories reset through per-entry valid bits, so there is no clearing pass
// a full output register holds the block in its output state until m_ready
`timescale 1ns / 1ps

module fir_filter_circular_delay_top #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [fircd_pkg::CMD_W-1:0]      s_command,
    input  logic signed [SAMPLE_WIDTH-1:0]   s_sample_in,
    input  logic                             s_block_last_in,
    input  logic [fircd_pkg::TAP_IDX_W-1:0]  s_tap_index,
    input  logic signed [COEF_WIDTH-1:0]     s_tap_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   m_sample_out,
    output logic                             m_saturated,
    output logic                             m_block_last_out,
    input  logic                             cfg_wr_en,
    input  logic [fircd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fircd_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import fircd_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    fircd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .sts       (sts),
        .cmd       (cmd)
    );

    fircd_dp #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_sample_in      (s_sample_in),
        .s_block_last_in  (s_block_last_in),
        .s_tap_index      (s_tap_index),
        .s_tap_value      (s_tap_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample_out     (m_sample_out),
        .m_saturated      (m_saturated),
        .m_block_last_out (m_block_last_out)
    );

endmodule
